@@ hdl/shcg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package shcg_pkg;

  localparam int FractionBitsDefault = 8;

  // FNV-1a, 32 bit.
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  // Hue reduction: floor(h / 360) = ((h >> 3) * HueRecip) >> HueShift for any 32-bit h.
  localparam logic [8:0]  HueModulus = 9'd360;
  localparam logic [29:0] HueRecip   = 30'd763549742;
  localparam int          HueShift   = 35;

  // Configuration register indexes.
  localparam logic RegSaturation = 1'b0;
  localparam logic RegBrightness = 1'b1;

  localparam logic [8:0] SaturationReset = 9'd230;
  localparam logic [8:0] BrightnessReset = 9'd236;
  localparam logic [8:0] LevelFull       = 9'd256;

  // Rec.709 luminance in integer form.
  localparam int LumWidth = 22;
  localparam logic [LumWidth-1:0] LumRed       = 22'd2126;
  localparam logic [LumWidth-1:0] LumGreen     = 22'd7152;
  localparam logic [LumWidth-1:0] LumBlue      = 22'd722;
  localparam logic [LumWidth-1:0] LumThreshold = 22'd1530000;

  typedef struct packed {
    logic accept;
    logic fold_hi;
    logic hash_init;
    logic hue_mul;
    logic hue_rem;
    logic color_en;
    logic prod_en;
    logic x_mul;
    logic mix_en;
    logic out_load;
  } shcg_cmd_t;

  typedef struct packed {
    logic last_flag;
    logic out_free;
  } shcg_status_t;

endpackage

`default_nettype wire

@@ hdl/seeded_hue_color_generator.sv @@
// Seeded hue colour generator.
// Seed characters arrive on the s_axis channel, one 16-bit code unit per request,
// with tlast marking the final one. Each character is folded into a 32-bit FNV-1a
// hash, low byte then high byte; the input channel takes no new character while
// the high byte is folded. On the last character the hash is reduced modulo 360
// to a hue and converted to RGB bytes with the saturation and brightness
// registers; the hash then returns to the offset basis for the next seed.
// The result leaves on m_axis: tdata holds red, green, blue; tuser is high when
// black text contrasts with the colour. After the last character is accepted, the
// controller steps through the high byte, the hue reciprocal multiply, the
// remainder, sector and chroma, the product, the division by sixty, the mix and
// the output load before m_axis_tvalid rises, and the input waits until the load.
// While the receiver stalls, the result sits in the output register and the
// next seed is still taken until its own result is ready; the input then waits.
// The cfg channel is always ready: index 0 writes saturation, index 1 brightness,
// both as fractions of 256. Write it only while the block is idle.
// Reset restores the offset basis, saturation 230 and brightness 236, and drops
// any pending result.
`timescale 1ns / 1ps
`default_nettype none

module seeded_hue_color_generator #(
  parameter int FRACTION_BITS = shcg_pkg::FractionBitsDefault
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // char_code
  input  wire         s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tuser,   // dark_text
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [8:0]  cfg_data
);

  shcg_pkg::shcg_cmd_t    cmd;
  shcg_pkg::shcg_status_t status;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {blue, green, red};

  shcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  shcg_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .char_code (s_axis_tdata),
    .last_char (s_axis_tlast),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_red   (red),
    .out_green (green),
    .out_blue  (blue),
    .out_dark  (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ hdl/shcg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shcg_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  shcg_pkg::shcg_status_t status,
  output shcg_pkg::shcg_cmd_t    cmd
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StHigh  = 4'd1;
  localparam logic [3:0] StHMul  = 4'd2;
  localparam logic [3:0] StHRem  = 4'd3;
  localparam logic [3:0] StColor = 4'd4;
  localparam logic [3:0] StProd  = 4'd5;
  localparam logic [3:0] StXMul  = 4'd6;
  localparam logic [3:0] StMix   = 4'd7;
  localparam logic [3:0] StLum   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == StIdle);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = StHigh;
        end
      end
      StHigh: begin
        cmd.fold_hi = 1'b1;
        state_next  = status.last_flag ? StHMul : StIdle;
      end
      StHMul: begin
        cmd.hue_mul   = 1'b1;
        cmd.hash_init = 1'b1;
        state_next    = StHRem;
      end
      StHRem: begin
        cmd.hue_rem = 1'b1;
        state_next  = StColor;
      end
      StColor: begin
        cmd.color_en = 1'b1;
        state_next   = StProd;
      end
      StProd: begin
        cmd.prod_en = 1'b1;
        state_next  = StXMul;
      end
      StXMul: begin
        cmd.x_mul  = 1'b1;
        state_next = StMix;
      end
      StMix: begin
        cmd.mix_en = 1'b1;
        state_next = StLum;
      end
      StLum: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/shcg_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shcg_dp #(
  parameter int FRACTION_BITS = shcg_pkg::FractionBitsDefault
) (
  input  wire                    clk,
  input  wire                    rst,
  input  shcg_pkg::shcg_cmd_t    cmd,
  output shcg_pkg::shcg_status_t status,
  input  wire  [15:0]            char_code,
  input  wire                    last_char,
  input  wire                    cfg_write,
  input  wire                    cfg_index,
  input  wire  [8:0]             cfg_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic                   out_dark
);

  localparam int CW = FRACTION_BITS + 1;
  localparam int PW = FRACTION_BITS + 7;
  localparam int SW = FRACTION_BITS + 10;
  localparam int LumWidth_c = shcg_pkg::LumWidth;
  localparam int HW = shcg_pkg::HueShift + 9;

  // floor(p / 60) = ((p >> 2) * XRecip) >> XShift for any p below 2^PW.
  localparam int XShift  = FRACTION_BITS + 9;
  localparam int XRecipW = FRACTION_BITS + 6;
  localparam int XPW     = XShift + CW;
  localparam logic [XRecipW-1:0] XRecip = XRecipW'(((64'd1 << XShift) + 64'd14) / 64'd15);

  logic [31:0] hash;
  logic [7:0]  high_byte;
  logic        last_flag;
  logic [8:0]  sat_level;
  logic [8:0]  bri_level;

  // Hue reduction.
  logic [8:0]  hash_low;
  logic [8:0]  hue_q;
  logic [8:0]  rem;

  // Colour stages.
  logic [2:0]    sector;
  logic [5:0]    t_frac;
  logic [CW-1:0] chroma;
  logic [CW-1:0] vfix;
  logic [PW-1:0] prod;
  logic [CW-1:0] x_val;
  logic [7:0]    red;
  logic [7:0]    green;
  logic [7:0]    blue;

  logic [2:0]    sector_next;
  logic [8:0]    sector_base;
  logic [8:0]    hue_off;
  logic [5:0]    t_next;
  logic [8:0]    sat_use;
  logic [8:0]    bri_use;
  logic [17:0]   vs_prod;
  logic [SW-1:0] vs_shift;
  logic [CW-1:0] vfix_next;
  logic [CW-1:0] chroma_next;
  logic [CW-1:0] m_val;
  logic [CW-1:0] r1;
  logic [CW-1:0] g1;
  logic [CW-1:0] b1;
  logic [LumWidth_c-1:0] lum;

  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * shcg_pkg::FnvPrime;
  endfunction

  function automatic logic [7:0] to_byte(input logic [CW-1:0] ch);
    logic [FRACTION_BITS+8:0] scaled;
    logic [8:0]               whole;
    scaled = {ch, 8'd0} - {8'd0, ch};
    whole  = scaled[FRACTION_BITS+8:FRACTION_BITS];
    return (whole > 9'd255) ? 8'd255 : whole[7:0];
  endfunction

  // Hash, latched character and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= shcg_pkg::FnvBasis;
      sat_level <= shcg_pkg::SaturationReset;
      bri_level <= shcg_pkg::BrightnessReset;
    end else begin
      if (cmd.accept) begin
        hash <= fnv_fold(hash, char_code[7:0]);
      end else if (cmd.fold_hi) begin
        hash <= fnv_fold(hash, high_byte);
      end else if (cmd.hash_init) begin
        hash <= shcg_pkg::FnvBasis;
      end
      if (cfg_write) begin
        case (cfg_index)
          shcg_pkg::RegSaturation: sat_level <= cfg_data;
          shcg_pkg::RegBrightness: bri_level <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      high_byte <= char_code[15:8];
      last_flag <= last_char;
    end
  end

  // The remainder is below 512, so the low nine bits of the hash and of the
  // quotient are enough to form it.
  always_ff @(posedge clk) begin
    if (cmd.hue_mul) begin
      hue_q    <= 9'((HW'(hash[31:3]) * HW'(shcg_pkg::HueRecip)) >> shcg_pkg::HueShift);
      hash_low <= hash[8:0];
    end
    if (cmd.hue_rem) begin
      rem <= hash_low - hue_q * shcg_pkg::HueModulus;
    end
  end

  // Hue sector and offset from the remainder; chroma and brightness from the levels.
  always_comb begin
    if (rem >= 9'd300) begin
      sector_next = 3'd5;
      sector_base = 9'd300;
    end else if (rem >= 9'd240) begin
      sector_next = 3'd4;
      sector_base = 9'd240;
    end else if (rem >= 9'd180) begin
      sector_next = 3'd3;
      sector_base = 9'd180;
    end else if (rem >= 9'd120) begin
      sector_next = 3'd2;
      sector_base = 9'd120;
    end else if (rem >= 9'd60) begin
      sector_next = 3'd1;
      sector_base = 9'd60;
    end else begin
      sector_next = 3'd0;
      sector_base = 9'd0;
    end
    hue_off = rem - sector_base;
    t_next  = sector_next[0] ? (6'd60 - hue_off[5:0]) : hue_off[5:0];

    sat_use     = (sat_level > shcg_pkg::LevelFull) ? shcg_pkg::LevelFull : sat_level;
    bri_use     = (bri_level > shcg_pkg::LevelFull) ? shcg_pkg::LevelFull : bri_level;
    vs_prod     = {9'd0, bri_use} * {9'd0, sat_use};
    vs_shift    = SW'(vs_prod) << (FRACTION_BITS - 8);
    chroma_next = vs_shift[FRACTION_BITS+8:8];
    vfix_next   = CW'(bri_use) << (FRACTION_BITS - 8);
  end

  always_ff @(posedge clk) begin
    if (cmd.color_en) begin
      sector <= sector_next;
      t_frac <= t_next;
      chroma <= chroma_next;
      vfix   <= vfix_next;
    end
    if (cmd.prod_en) begin
      prod <= PW'(chroma) * PW'(t_frac);
    end
    if (cmd.x_mul) begin
      x_val <= CW'((XPW'(prod[PW-1:2]) * XPW'(XRecip)) >> XShift);
    end
  end

  // Channel mix and conversion to bytes.
  always_comb begin
    m_val = vfix - chroma;
    r1    = '0;
    g1    = '0;
    b1    = '0;
    case (sector)
      3'd0: begin
        r1 = chroma;
        g1 = x_val;
      end
      3'd1: begin
        r1 = x_val;
        g1 = chroma;
      end
      3'd2: begin
        g1 = chroma;
        b1 = x_val;
      end
      3'd3: begin
        g1 = x_val;
        b1 = chroma;
      end
      3'd4: begin
        r1 = x_val;
        b1 = chroma;
      end
      default: begin
        r1 = chroma;
        b1 = x_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mix_en) begin
      red   <= to_byte(r1 + m_val);
      green <= to_byte(g1 + m_val);
      blue  <= to_byte(b1 + m_val);
    end
  end

  assign lum = shcg_pkg::LumRed * LumWidth_c'(red)
             + shcg_pkg::LumGreen * LumWidth_c'(green)
             + shcg_pkg::LumBlue * LumWidth_c'(blue);

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red   <= red;
      out_green <= green;
      out_blue  <= blue;
      out_dark  <= (lum > shcg_pkg::LumThreshold);
    end
  end

  assign status.last_flag = last_flag;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ tb/sv/seeded_hue_color_generator_tb.sv @@
`timescale 1ns / 1ps

module seeded_hue_color_generator_tb;

  localparam int FracBits = shcg_pkg::FractionBitsDefault;
  localparam logic [31:0] HashBasis = 32'h811C9DC5;
  localparam logic [31:0] HashPrime = 32'h01000193;
  localparam logic [8:0] SatAtReset = 9'd230;
  localparam logic [8:0] BrightAtReset = 9'd236;
  localparam int StallLimit = 5000;
  localparam int SettleCycles = 40;
  localparam int DrainCycles = 60;
  localparam int PhaseCount = 8;
  localparam int CharsPerPhase = 235;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       dark;
  } color_t;

  class seed_color_checker;
    logic [31:0] hash;
    logic [8:0]  sat_level;
    logic [8:0]  bright_level;
    color_t      colors_due[$];
    int          errors;

    function new();
      hash = HashBasis;
      sat_level = SatAtReset;
      bright_level = BrightAtReset;
      errors = 0;
    endfunction

    function void write_level(logic index, logic [8:0] value);
      if (index == shcg_pkg::RegSaturation) begin
        sat_level = value;
      end else begin
        bright_level = value;
      end
    endfunction

    function logic [7:0] to_byte(logic [63:0] level);
      logic [63:0] scaled;
      scaled = (level * 64'd255) >> FracBits;
      return (scaled > 64'd255) ? 8'd255 : scaled[7:0];
    endfunction

    function color_t hue_to_color(int unsigned hue);
      logic [63:0] s, v, vfix, c, x, m, r1, g1, b1;
      int unsigned sector, frac, t;
      color_t col;
      logic [63:0] lum;
      s = (sat_level > 9'd256) ? 64'd256 : 64'(sat_level);
      v = (bright_level > 9'd256) ? 64'd256 : 64'(bright_level);
      vfix = (v << FracBits) >> 8;
      c = ((v * s) << FracBits) >> 16;
      sector = hue / 60;
      frac = hue % 60;
      t = (sector % 2 == 1) ? (60 - frac) : frac;
      x = (c * t) / 60;
      m = (vfix >= c) ? vfix - c : 64'd0;
      r1 = 0;
      g1 = 0;
      b1 = 0;
      case (sector)
        0: begin
          r1 = c; g1 = x;
        end
        1: begin
          r1 = x; g1 = c;
        end
        2: begin
          g1 = c; b1 = x;
        end
        3: begin
          g1 = x; b1 = c;
        end
        4: begin
          r1 = x; b1 = c;
        end
        default: begin
          r1 = c; b1 = x;
        end
      endcase
      col.red = to_byte(r1 + m);
      col.green = to_byte(g1 + m);
      col.blue = to_byte(b1 + m);
      lum = 64'd2126 * col.red + 64'd7152 * col.green + 64'd722 * col.blue;
      col.dark = (lum > 64'd1530000);
      return col;
    endfunction

    // Low byte first, then high byte, each an xor followed by a multiply.
    function void take_char(logic [15:0] code, logic last);
      hash = (hash ^ {24'd0, code[7:0]}) * HashPrime;
      hash = (hash ^ {24'd0, code[15:8]}) * HashPrime;
      if (last) begin
        colors_due.insert(colors_due.size(), hue_to_color(hash % 360));
        hash = HashBasis;
      end
    endfunction

    function void check_color(logic [23:0] data, logic dark);
      color_t want;
      if (colors_due.size() == 0) begin
        $display("%0t: unexpected result, actual rgb %h dark %0b", $time, data, dark);
        errors++;
        return;
      end
      want = colors_due.pop_front();
      if (data[7:0] != want.red) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, data[7:0]);
        errors++;
      end
      if (data[15:8] != want.green) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, data[15:8]);
        errors++;
      end
      if (data[23:16] != want.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, data[23:16]);
        errors++;
      end
      if (dark != want.dark) begin
        $display("%0t: dark_text expected %0b actual %0b", $time, want.dark, dark);
        errors++;
      end
    endfunction

    function int pending();
      return colors_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;

  seed_color_checker checker_h = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  seeded_hue_color_generator DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted request is seen here, at the rising edge it completes on.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        checker_h.take_char(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        checker_h.check_color(m_axis_tdata, m_axis_tuser);
      end
      if (cfg_valid && cfg_ready) begin
        checker_h.write_level(cfg_index, cfg_data);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_char(logic [15:0] code, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= code;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic set_levels(logic [8:0] sat, logic [8:0] bright);
    cfg_valid <= 1'b1;
    cfg_index <= shcg_pkg::RegSaturation;
    cfg_data <= sat;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= shcg_pkg::RegBrightness;
    cfg_data <= bright;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Characters that end no seed may still be folding after the last colour arrives.
  task automatic wait_drained();
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_char();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(16'h7E, 16'h20));
      5: return 16'($urandom_range(16'h07FF, 16'h0100));
      default: return 16'($urandom_range(16'hFFFF, 0));
    endcase
  endfunction

  task automatic random_seeds(int count);
    int sent, len, kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(19);
      if (kind < 14) begin
        len = $urandom_range(4, 1);
      end else if (kind < 19) begin
        len = $urandom_range(12, 5);
      end else begin
        len = $urandom_range(40, 13);
      end
      for (int i = 0; i < len; i++) begin
        send_char(pick_char(), i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic directed_seeds();
    send_char(16'h0000, 1'b1);
    send_char(16'hFFFF, 1'b1);
    send_char(16'h0041, 1'b1);
    send_char(16'h0041, 1'b0);
    send_char(16'h0062, 1'b1);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b1);
    send_char(16'h00FF, 1'b0);
    send_char(16'hFF00, 1'b1);
    send_char(16'h8000, 1'b0);
    send_char(16'h0001, 1'b1);
    send_char(16'h5555, 1'b0);
    send_char(16'hAAAA, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_char(16'(16'h0030 + i), i == 7);
    end
  endtask

  initial begin
    logic [8:0] sat_list [PhaseCount];
    logic [8:0] bright_list [PhaseCount];
    sat_list = '{9'd230, 9'd0, 9'd256, 9'd511, 9'd300, 9'd256, 9'd0, 9'd230};
    bright_list = '{9'd236, 9'd0, 9'd256, 9'd511, 9'd210, 9'd0, 9'd256, 9'd236};
    sat_list[PhaseCount-1] = 9'($urandom_range(511));
    bright_list[PhaseCount-1] = 9'($urandom_range(511));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct = 23;
          recv_stall_pct = 23;
        end
      endcase
      // The first phase runs on the reset levels.
      if (phase > 0) begin
        wait_drained();
        set_levels(sat_list[phase], bright_list[phase]);
      end else begin
        directed_seeds();
      end
      random_seeds(CharsPerPhase);
      s_axis_tvalid <= 1'b0;
    end
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (checker_h.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
